### design/hashed_identity_intern_table_assert.svh
// Assertion macros for the checker of the intern table.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef HASHED_IDENTITY_INTERN_TABLE_ASSERT_SVH
`define HASHED_IDENTITY_INTERN_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HITAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HITAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hitab_pkg.sv
`default_nettype none
package hitab_pkg;

  localparam int SLOT_BITS     = 12;
  localparam int KIND_BITS     = 3;
  localparam int REF_BITS      = SLOT_BITS + KIND_BITS;
  localparam int NAME_BITS     = 32;
  localparam int BUCKET_BITS_D = 10;

  localparam logic [1:0] CMD_DECLARE = 2'd0;
  localparam logic [1:0] CMD_FIND    = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_INVALID       = 3'd1;
  localparam logic [2:0] ST_NOT_AVAILABLE = 3'd2;
  localparam logic [2:0] ST_CONFLICT      = 3'd3;
  localparam logic [2:0] ST_INIT_FAILED   = 3'd4;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_S0 = 30;
  localparam int MIX_S1 = 27;
  localparam int MIX_S2 = 31;
  localparam int HALF   = 32;

  typedef struct packed {
    logic [1:0]           command;
    logic [SLOT_BITS-1:0] parent_slot;
    logic [KIND_BITS-1:0] parent_kind;
    logic [NAME_BITS-1:0] name_id;
    logic [KIND_BITS-1:0] entry_kind;
    logic [SLOT_BITS-1:0] query_slot;
    logic [KIND_BITS-1:0] query_kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [SLOT_BITS-1:0] result_slot;
    logic [KIND_BITS-1:0] result_kind;
    logic                 is_valid;
    logic [SLOT_BITS-1:0] owner_slot;
    logic [KIND_BITS-1:0] owner_kind;
    logic [NAME_BITS-1:0] owner_name;
  } out_item_t;

  typedef struct packed {
    logic [REF_BITS-1:0]  link;
    logic [REF_BITS-1:0]  parent;
    logic [NAME_BITS-1:0] name;
    logic [KIND_BITS-1:0] kind;
    logic [SLOT_BITS-1:0] fp;
  } rec_t;

endpackage
`default_nettype wire

### design/hitab_ram.sv
`default_nettype none
module hitab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/hitab_hash.sv
`default_nettype none
module hitab_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] key,
  output logic             done,
  output logic [63:0]      hash
);

  logic        busy_r, phase_r, done_r;
  logic [1:0]  cnt_r;
  logic [63:0] v_r, acc_r, prod_r;
  logic [63:0] c_sel, acc_sum, mixed, prod_nxt;
  logic [31:0] op_a, op_b;

  // Three 32x32 partial products per 64-bit multiply, each registered and summed in the next cycle.
  always_comb begin
    c_sel    = phase_r ? hitab_pkg::MIX_C2 : hitab_pkg::MIX_C1;
    op_a     = (cnt_r == 2'd1) ? v_r[63:32] : v_r[31:0];
    op_b     = (cnt_r == 2'd2) ? c_sel[63:32] : c_sel[31:0];
    prod_nxt = {32'd0, op_a} * {32'd0, op_b};
    if (cnt_r == 2'd1) begin
      acc_sum = prod_r;
    end else begin
      acc_sum = acc_r + {prod_r[31:0], 32'd0};
    end
    if (phase_r) begin
      mixed = acc_sum ^ (acc_sum >> hitab_pkg::MIX_S2);
    end else begin
      mixed = acc_sum ^ (acc_sum >> hitab_pkg::MIX_S1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r     <= key ^ (key >> hitab_pkg::MIX_S0);
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= 2'd0;
      end else if (busy_r) begin
        prod_r <= prod_nxt;
        acc_r  <= acc_sum;
        cnt_r  <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          v_r <= mixed;
          if (phase_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            phase_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign hash = v_r;

endmodule
`default_nettype wire

### design/hashed_identity_intern_table.sv
// Sequence: a query reads and checks its record; declare/find reject a zero name or
//   kind, check the parent, hash the key, walk the bucket chain and resolve the result.
// Throughput: one item at a time; the next item enters once the result is in the
//   output register. The hash unit's shared 32x32 multiplier and the
//   one-read-per-cycle record memory limit the rate.
// Reset: control clears at once, then a pass writes all 2**BUCKET_BITS bucket heads
//   (1024 by default) to zero, with in_ready low throughout.
`default_nettype none
module hashed_identity_intern_table #(
  parameter int BUCKET_BITS = hitab_pkg::BUCKET_BITS_D
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hitab_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hitab_pkg::out_item_t      out_item
);

  localparam int SB  = hitab_pkg::SLOT_BITS;
  localparam int KB  = hitab_pkg::KIND_BITS;
  localparam int RB  = hitab_pkg::REF_BITS;
  localparam int NB  = hitab_pkg::NAME_BITS;
  localparam int HB  = hitab_pkg::HALF;

  // Sequencer states.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_QRD  = 4'd2;
  localparam logic [3:0] S_QEV  = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_PEV  = 4'd5;
  localparam logic [3:0] S_HASH = 4'd6;
  localparam logic [3:0] S_HRD  = 4'd7;
  localparam logic [3:0] S_HEV  = 4'd8;
  localparam logic [3:0] S_WRD  = 4'd9;
  localparam logic [3:0] S_WEV  = 4'd10;
  localparam logic [3:0] S_RES  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // Chain walk outcome.
  localparam logic [1:0] WALK_MISS   = 2'd0;
  localparam logic [1:0] WALK_HIT    = 2'd1;
  localparam logic [1:0] WALK_BROKEN = 2'd2;

  logic [3:0]             state_r, state_nxt;
  logic [BUCKET_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  hitab_pkg::in_item_t    in_r, in_nxt;
  hitab_pkg::out_item_t   res_r, res_nxt;
  hitab_pkg::out_item_t   out_item_r, out_item_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SB:0]            nf_r, nf_nxt;
  logic [SB-1:0]          fp_r, fp_nxt;
  logic [BUCKET_BITS-1:0] bucket_r, bucket_nxt;
  logic [RB-1:0]          head_r, head_nxt;
  logic [RB-1:0]          cur_r, cur_nxt;
  logic [RB-1:0]          hit_r, hit_nxt;
  logic [SB:0]            steps_r, steps_nxt;
  logic [1:0]             walk_r, walk_nxt;

  // Memory ports.
  logic                   rec_we;
  logic [SB-1:0]          rec_waddr, rec_raddr;
  hitab_pkg::rec_t        rec_wdata, rec_rdata;
  logic                   bkt_we;
  logic [BUCKET_BITS-1:0] bkt_waddr;
  logic [RB-1:0]          bkt_wdata, bkt_rdata;

  // Hash unit.
  logic                   hash_start, hash_done;
  logic [63:0]            hash_key, hash_val;
  logic [SB-1:0]          fp_raw;
  logic [RB-1:0]          pref;

  logic                   accept;

  // A record is published when it is a live slot with a nonzero fingerprint,
  // a matching kind and a nonzero name; the root counts only with kind 0.
  // Slots at or above the fill mark were never written and count as unpublished.
  function automatic logic pub_f(input logic [SB-1:0] slot, input logic [KB-1:0] kind,
                                 input hitab_pkg::rec_t d, input logic [SB:0] nf);
    logic ok;
    if (slot == '0) begin
      ok = 1'b0;
    end else if (slot == SB'(1)) begin
      ok = (kind == '0);
    end else begin
      ok = ({1'b0, slot} < nf) && (d.fp != '0) && (d.kind == kind) && (d.name != '0);
    end
    return ok;
  endfunction

  hitab_ram #(
    .WIDTH ($bits(hitab_pkg::rec_t)),
    .DEPTH (1 << SB)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  hitab_ram #(
    .WIDTH (RB),
    .DEPTH (1 << BUCKET_BITS)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bucket_r),
    .rdata (bkt_rdata)
  );

  hitab_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .hash  (hash_val)
  );

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Parent reference packs kind above slot; key puts the name in the high half.
  assign pref     = {in_r.parent_kind, in_r.parent_slot};
  assign hash_key = {in_r.name_id, {(HB - RB){1'b0}}, pref};
  assign fp_raw   = hash_val[SB-1:0] ^ hash_val[HB +: SB];

  always_comb begin
    unique case (state_r)
      S_QRD:   rec_raddr = in_r.query_slot;
      S_PRD:   rec_raddr = in_r.parent_slot;
      default: rec_raddr = cur_r[SB-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    in_nxt        = in_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    nf_nxt        = nf_r;
    fp_nxt        = fp_r;
    bucket_nxt    = bucket_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    hit_nxt       = hit_r;
    steps_nxt     = steps_r;
    walk_nxt      = walk_r;
    rec_we        = 1'b0;
    rec_waddr     = nf_r[SB-1:0];
    rec_wdata     = '0;
    bkt_we        = 1'b0;
    bkt_waddr     = bucket_r;
    bkt_wdata     = '0;
    hash_start    = 1'b0;

    // Drop the output once taken; a new result may refill it below.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        // Sweep the bucket heads to empty chains.
        bkt_we      = 1'b1;
        bkt_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + BUCKET_BITS'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          in_nxt  = in_item;
          res_nxt = '0;
          unique case (in_item.command)
            hitab_pkg::CMD_QUERY: begin
              state_nxt = S_QRD;
            end
            hitab_pkg::CMD_DECLARE, hitab_pkg::CMD_FIND: begin
              if (in_item.name_id == '0 || in_item.entry_kind == '0) begin
                res_nxt.status = hitab_pkg::ST_INVALID;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_PRD;
              end
            end
            default: begin
              res_nxt.status = hitab_pkg::ST_INVALID;
              state_nxt      = S_FIN;
            end
          endcase
        end
      end
      S_QRD: begin
        state_nxt = S_QEV;
      end
      S_QEV: begin
        if (pub_f(in_r.query_slot, in_r.query_kind, rec_rdata, nf_r)) begin
          res_nxt.is_valid = 1'b1;
          // The root has no stored record: owner stays zero.
          if (in_r.query_slot != SB'(1)) begin
            res_nxt.owner_slot = rec_rdata.parent[SB-1:0];
            res_nxt.owner_kind = rec_rdata.parent[RB-1:SB];
            res_nxt.owner_name = rec_rdata.name;
          end
        end
        state_nxt = S_FIN;
      end
      S_PRD: begin
        state_nxt = S_PEV;
      end
      S_PEV: begin
        if (pub_f(in_r.parent_slot, in_r.parent_kind, rec_rdata, nf_r)) begin
          hash_start = 1'b1;
          state_nxt  = S_HASH;
        end else begin
          res_nxt.status = hitab_pkg::ST_INVALID;
          state_nxt      = S_FIN;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          fp_nxt     = (fp_raw == '0) ? SB'(1) : fp_raw;
          bucket_nxt = hash_val[BUCKET_BITS-1:0];
          state_nxt  = S_HRD;
        end
      end
      S_HRD: begin
        state_nxt = S_HEV;
      end
      S_HEV: begin
        head_nxt  = bkt_rdata;
        cur_nxt   = bkt_rdata;
        steps_nxt = '0;
        if (bkt_rdata == '0) begin
          walk_nxt  = WALK_MISS;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        state_nxt = S_WEV;
      end
      S_WEV: begin
        // Visit one chain record: stop on a broken link, a match or chain end.
        if (steps_r[SB] || !pub_f(cur_r[SB-1:0], cur_r[RB-1:SB], rec_rdata, nf_r)) begin
          walk_nxt  = WALK_BROKEN;
          state_nxt = S_RES;
        end else begin
          steps_nxt = steps_r + (SB + 1)'(1);
          if (rec_rdata.fp == fp_r && rec_rdata.parent == pref &&
              rec_rdata.name == in_r.name_id) begin
            hit_nxt   = cur_r;
            walk_nxt  = WALK_HIT;
            state_nxt = S_RES;
          end else begin
            cur_nxt = rec_rdata.link;
            if (rec_rdata.link == '0) begin
              walk_nxt  = WALK_MISS;
              state_nxt = S_RES;
            end else begin
              state_nxt = S_WRD;
            end
          end
        end
      end
      S_RES: begin
        state_nxt = S_FIN;
        if (in_r.command == hitab_pkg::CMD_FIND) begin
          if (walk_r == WALK_HIT && hit_r[RB-1:SB] == in_r.entry_kind) begin
            res_nxt.result_slot = hit_r[SB-1:0];
            res_nxt.result_kind = hit_r[RB-1:SB];
          end
        end else if (walk_r == WALK_HIT) begin
          if (hit_r[RB-1:SB] != in_r.entry_kind) begin
            res_nxt.status = hitab_pkg::ST_CONFLICT;
          end else begin
            res_nxt.result_slot = hit_r[SB-1:0];
            res_nxt.result_kind = hit_r[RB-1:SB];
          end
        end else if (nf_r[SB]) begin
          res_nxt.status = hitab_pkg::ST_NOT_AVAILABLE;
        end else begin
          // Consume the next slot; a broken chain leaves it cleared and unlinked.
          nf_nxt    = nf_r + (SB + 1)'(1);
          rec_we    = 1'b1;
          rec_waddr = nf_r[SB-1:0];
          if (walk_r == WALK_BROKEN) begin
            res_nxt.status = hitab_pkg::ST_INIT_FAILED;
          end else begin
            rec_wdata.link   = head_r;
            rec_wdata.parent = pref;
            rec_wdata.name   = in_r.name_id;
            rec_wdata.kind   = in_r.entry_kind;
            rec_wdata.fp     = fp_r;
            bkt_we           = 1'b1;
            bkt_waddr        = bucket_r;
            bkt_wdata        = {in_r.entry_kind, nf_r[SB-1:0]};
            res_nxt.result_slot = nf_r[SB-1:0];
            res_nxt.result_kind = in_r.entry_kind;
          end
        end
      end
      S_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      nf_r        <= (SB + 1)'(2);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      nf_r        <= nf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
    fp_r       <= fp_nxt;
    bucket_r   <= bucket_nxt;
    head_r     <= head_nxt;
    cur_r      <= cur_nxt;
    hit_r      <= hit_nxt;
    steps_r    <= steps_nxt;
    walk_r     <= walk_nxt;
  end

endmodule
`default_nettype wire

### design/hitab_checker.sv
`default_nettype none
`include "hashed_identity_intern_table_assert.svh"
module hitab_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire hitab_pkg::out_item_t out_item
);

  `HITAB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled output item changed")
  `HITAB_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item taken while busy")
  `HITAB_ASSERT_IMP(a_query_clean, out_valid && out_item.is_valid, out_item.result_slot == '0 && out_item.status == hitab_pkg::ST_OK, "query result carries entry fields")
  `HITAB_ASSERT_IMP(a_owner_zero, out_valid && !out_item.is_valid, out_item.owner_slot == '0 && out_item.owner_name == '0, "owner fields set without valid record")
  `HITAB_ASSERT_IMP(a_entry_ok, out_valid && out_item.result_slot != '0, out_item.status == hitab_pkg::ST_OK && out_item.result_kind != '0, "entry returned with bad status or root kind")

endmodule

bind hashed_identity_intern_table hitab_checker u_hitab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
